[rtl/two_bucket_first_fit_allocator_unit_defines.svh]
// Assertion macros for the two-bucket first-fit allocator checker.
// Used only by the checker file; it has no other dependencies.
`ifndef TWO_BUCKET_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define TWO_BUCKET_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TBFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbfa assertion failed");

// Next-cycle implication, disabled while reset is held
`define TBFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbfa assertion failed");

`endif

[rtl/tbfa_pkg.sv]
// Package for the two-bucket first-fit allocator: state type, field widths
// and header encoding. No dependencies.
`timescale 1ns / 1ps

package tbfa_pkg;

    // Fixed field widths
    localparam int SIZE_W     = 16;
    localparam int OFF_W      = 14;
    localparam int HDR_W      = 16;
    localparam int LEN_W      = 15;
    localparam int NEED_W     = 17;

    // Allocation unit and header layout
    localparam int UNIT_BYTES = 4;
    localparam int UNIT_SHIFT = 2;
    localparam int IN_USE_BIT = 15;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_FREE,
        ST_PLACE,
        ST_MARK,
        ST_DONE
    } t_state;

endpackage

[rtl/two_bucket_first_fit_allocator_unit.sv]
// Top level of the two-bucket first-fit allocator: sequencer, walk datapath
// and output register. Depends on tbfa_pkg and tbfa_hdr_ram.
`timescale 1ns / 1ps
//
//  channel   valid         ready         payload
//  -------   -----------   -----------   ------------------------------------
//  request   i_in_valid    o_in_ready    i_req_type, i_req_size, i_free_offset
//  result    o_out_valid   i_out_ready   o_ok, o_block_offset
//
//  After reset an init pass writes the bucket headers and sentinels. A free
//  reads the block header, clears the in-use mark and reports; a rejected
//  offset skips the read. An allocate reads the headers in turn, sentinel
//  included, then places the block (split header first) and reports.
//  A new request is taken while the last result waits in the output register;
//  a stalled result holds the sequencer in its final state.

module two_bucket_first_fit_allocator_unit #(
    parameter int SMALL_BUCKET_BYTES = 4096,
    parameter int BIG_BUCKET_BYTES   = 6144,
    parameter int SMALL_LIMIT_BYTES  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic [tbfa_pkg::SIZE_W-1:0]  i_req_size,
    input  logic [tbfa_pkg::OFF_W-1:0]   i_free_offset,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_ok,
    output logic [tbfa_pkg::OFF_W-1:0]   o_block_offset
);

    localparam int LEN_W      = tbfa_pkg::LEN_W;
    localparam int HDR_W      = tbfa_pkg::HDR_W;
    localparam int NEED_W     = tbfa_pkg::NEED_W;
    localparam int OFF_W      = tbfa_pkg::OFF_W;
    localparam int UNIT       = tbfa_pkg::UNIT_BYTES;

    localparam int SMALL_HEAD_IDX = 0;
    localparam int SMALL_END_IDX  = SMALL_BUCKET_BYTES / UNIT + 1;
    localparam int BIG_HEAD_IDX   = SMALL_END_IDX + 1;
    localparam int BIG_END_IDX    = BIG_HEAD_IDX + BIG_BUCKET_BYTES / UNIT + 1;
    localparam int STORE_DEPTH    = BIG_END_IDX + 1;
    localparam int IDX_W          = $clog2(STORE_DEPTH);
    localparam int SUM_W          = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;
    localparam int SMALL_LIMIT_RND = ((SMALL_LIMIT_BYTES + UNIT - 1) / UNIT) * UNIT;

    localparam logic [HDR_W-1:0] SMALL_HDR = HDR_W'(SMALL_BUCKET_BYTES) & 16'h7FFF;
    localparam logic [HDR_W-1:0] BIG_HDR   = HDR_W'(BIG_BUCKET_BYTES) & 16'h7FFF;

    // Sequencer and walk registers
    tbfa_pkg::t_state   r_state, n_state;
    logic [1:0]         r_init_cnt, n_init_cnt;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic [LEN_W-1:0]   r_prev_len, n_prev_len;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [NEED_W-1:0]  r_need, n_need;
    logic               r_merging, n_merging;
    logic               r_first, n_first;
    logic               r_res_ok, n_res_ok;
    logic [OFF_W-1:0]   r_res_off, n_res_off;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic               r_out_ok, n_out_ok;
    logic [OFF_W-1:0]   r_out_off, n_out_off;

    // Header store port
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [HDR_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [HDR_W-1:0]   mem_rdata;

    // Request decode
    logic [NEED_W-1:0]  size_rnd;
    logic [NEED_W-1:0]  need_c;
    logic               small_c;
    logic [SUM_W-1:0]   free_idx;
    logic               free_ok;

    // Walk and placement datapath
    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   merge_len;
    logic [SUM_W-1:0]   nxt_idx;
    logic [LEN_W-1:0]   rem_len;
    logic [SUM_W-1:0]   split_idx;
    logic [OFF_W-1:0]   data_off;
    logic               walk_found;

    tbfa_hdr_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (HDR_W)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Round the size up to whole units; zero becomes one unit
    assign size_rnd = {1'b0, i_req_size} + NEED_W'(UNIT - 1);
    assign need_c   = (size_rnd[NEED_W-1:tbfa_pkg::UNIT_SHIFT] == '0) ? NEED_W'(UNIT)
                    : {size_rnd[NEED_W-1:tbfa_pkg::UNIT_SHIFT], 2'b00};
    assign small_c  = (need_c <= NEED_W'(SMALL_LIMIT_RND));

    // Free offset checks: aligned, at least one unit, header inside the store
    assign free_idx = SUM_W'(i_free_offset[OFF_W-1:tbfa_pkg::UNIT_SHIFT]) - SUM_W'(1);
    assign free_ok  = (i_free_offset[1:0] == 2'b00)
                   && (i_free_offset[OFF_W-1:tbfa_pkg::UNIT_SHIFT] != '0)
                   && (free_idx < SUM_W'(STORE_DEPTH));

    // Adders for the walk and the split
    assign hdr_len   = mem_rdata[LEN_W-1:0];
    assign merge_len = r_prev_len + hdr_len + LEN_W'(UNIT);
    assign nxt_idx   = SUM_W'(r_cur) + SUM_W'(hdr_len[LEN_W-1:tbfa_pkg::UNIT_SHIFT])
                     + SUM_W'(1);
    assign rem_len   = r_len - r_need[LEN_W-1:0];
    assign split_idx = SUM_W'(r_cur) + SUM_W'(r_need[NEED_W-1:tbfa_pkg::UNIT_SHIFT])
                     + SUM_W'(1);
    assign data_off  = OFF_W'((SUM_W'(r_cur) + SUM_W'(1)) << tbfa_pkg::UNIT_SHIFT);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbfa_pkg::ST_INIT;
            r_init_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_cnt  <= n_init_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_prev_len <= n_prev_len;
        r_len      <= n_len;
        r_need     <= n_need;
        r_merging  <= n_merging;
        r_first    <= n_first;
        r_res_ok   <= n_res_ok;
        r_res_off  <= n_res_off;
        r_out_ok   <= n_out_ok;
        r_out_off  <= n_out_off;
    end

    // Next state and store control
    always_comb begin
        n_state     = r_state;
        n_init_cnt  = r_init_cnt;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_len  = r_prev_len;
        n_len       = r_len;
        n_need      = r_need;
        n_merging   = r_merging;
        n_first     = r_first;
        n_res_ok    = r_res_ok;
        n_res_off   = r_res_off;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_off   = r_out_off;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        walk_found  = 1'b0;

        // Drop the result once transferred
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            tbfa_pkg::ST_INIT: begin
                // Write bucket headers and sentinels, one per cycle
                mem_we     = 1'b1;
                n_init_cnt = r_init_cnt + 2'd1;
                unique case (r_init_cnt)
                    2'd0: begin
                        mem_waddr = IDX_W'(SMALL_HEAD_IDX);
                        mem_wdata = SMALL_HDR;
                    end
                    2'd1: begin
                        mem_waddr = IDX_W'(SMALL_END_IDX);
                    end
                    2'd2: begin
                        mem_waddr = IDX_W'(BIG_HEAD_IDX);
                        mem_wdata = BIG_HDR;
                    end
                    default: begin
                        mem_waddr = IDX_W'(BIG_END_IDX);
                        n_state   = tbfa_pkg::ST_IDLE;
                    end
                endcase
            end

            tbfa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == tbfa_pkg::REQ_ALLOC) begin
                        // Start the walk at the bucket head
                        n_need    = need_c;
                        n_cur     = small_c ? IDX_W'(SMALL_HEAD_IDX) : IDX_W'(BIG_HEAD_IDX);
                        mem_re    = 1'b1;
                        mem_raddr = n_cur;
                        n_merging = 1'b0;
                        n_first   = 1'b1;
                        n_state   = tbfa_pkg::ST_WALK;
                    end else if (free_ok) begin
                        n_cur     = free_idx[IDX_W-1:0];
                        mem_re    = 1'b1;
                        mem_raddr = free_idx[IDX_W-1:0];
                        n_state   = tbfa_pkg::ST_FREE;
                    end else begin
                        n_res_ok  = 1'b0;
                        n_res_off = '0;
                        n_state   = tbfa_pkg::ST_DONE;
                    end
                end
            end

            tbfa_pkg::ST_WALK: begin
                if (!r_first && mem_rdata == '0) begin
                    // Hit the sentinel: no fit
                    n_res_ok  = 1'b0;
                    n_res_off = '0;
                    n_state   = tbfa_pkg::ST_DONE;
                end else begin
                    n_first = 1'b0;
                    if (mem_rdata[tbfa_pkg::IN_USE_BIT]) begin
                        n_merging = 1'b0;
                    end else if (r_merging) begin
                        // Fold this block and its header into the open run
                        mem_we     = 1'b1;
                        mem_waddr  = r_prev;
                        mem_wdata  = {1'b0, merge_len};
                        n_prev_len = merge_len;
                        if (NEED_W'(merge_len) >= r_need) begin
                            walk_found = 1'b1;
                            n_cur      = r_prev;
                            n_len      = merge_len;
                        end
                    end else if (NEED_W'(hdr_len) >= r_need) begin
                        walk_found = 1'b1;
                        n_len      = hdr_len;
                    end else begin
                        n_merging  = 1'b1;
                        n_prev     = r_cur;
                        n_prev_len = hdr_len;
                    end

                    if (walk_found) begin
                        n_state = tbfa_pkg::ST_PLACE;
                    end else if (nxt_idx >= SUM_W'(STORE_DEPTH)) begin
                        n_res_ok  = 1'b0;
                        n_res_off = '0;
                        n_state   = tbfa_pkg::ST_DONE;
                    end else begin
                        // Advance to the next header
                        mem_re    = 1'b1;
                        mem_raddr = nxt_idx[IDX_W-1:0];
                        n_cur     = nxt_idx[IDX_W-1:0];
                    end
                end
            end

            tbfa_pkg::ST_PLACE: begin
                n_res_ok  = 1'b1;
                n_res_off = data_off;
                mem_we    = 1'b1;
                if (rem_len > LEN_W'(UNIT) && split_idx < SUM_W'(STORE_DEPTH)) begin
                    // Split: header for the remainder first
                    mem_waddr = split_idx[IDX_W-1:0];
                    mem_wdata = {1'b0, rem_len - LEN_W'(UNIT)};
                    n_state   = tbfa_pkg::ST_MARK;
                end else begin
                    mem_waddr = r_cur;
                    mem_wdata = {1'b1, r_len};
                    n_state   = tbfa_pkg::ST_DONE;
                end
            end

            tbfa_pkg::ST_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = {1'b1, r_need[LEN_W-1:0]};
                n_state   = tbfa_pkg::ST_DONE;
            end

            tbfa_pkg::ST_FREE: begin
                // Clear the in-use mark; ignore a block already free
                n_res_off = '0;
                if (mem_rdata[tbfa_pkg::IN_USE_BIT]) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = {1'b0, hdr_len};
                    n_res_ok  = 1'b1;
                end else begin
                    n_res_ok  = 1'b0;
                end
                n_state = tbfa_pkg::ST_DONE;
            end

            tbfa_pkg::ST_DONE: begin
                // Hand the result to the output register when it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_off   = r_res_off;
                    n_state     = tbfa_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tbfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready     = (r_state == tbfa_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_block_offset = r_out_off;

endmodule

[rtl/tbfa_hdr_ram.sv]
// Header store: one write port, one read port with registered read data.
// Uses no package items.
`timescale 1ns / 1ps

module tbfa_hdr_ram #(
    parameter int DEPTH  = 2564,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tbfa_checker.sv]
// Port-level checker for the two-bucket first-fit allocator, and its bind.
// Depends on tbfa_pkg and two_bucket_first_fit_allocator_unit_defines.svh.
`timescale 1ns / 1ps
`include "two_bucket_first_fit_allocator_unit_defines.svh"

module tbfa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_ok,
    input logic [tbfa_pkg::OFF_W-1:0]  o_block_offset
);

    // Hold a stalled result
    `TBFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_ok) && $stable(o_block_offset))

    // One request at a time: busy right after a transfer in
    `TBFA_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A failed request reports a zero offset
    `TBFA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && !o_ok, o_block_offset == '0)

    // Data offsets are whole units
    `TBFA_ASSERT_NOW(a_off_aligned, i_clk, i_rst_n, o_out_valid, o_block_offset[1:0] == 2'b00)

endmodule

bind two_bucket_first_fit_allocator_unit tbfa_checker u_tbfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_ok           (o_ok),
    .o_block_offset (o_block_offset)
);
